[hw/rtl/kecu_pkg.sv]
package kecu_pkg;

    // ascii codes of the sequence
    localparam logic [7:0] ASC_ESC   = 8'h1B;
    localparam logic [7:0] ASC_LBR   = 8'h5B;
    localparam logic [7:0] ASC_SEMI  = 8'h3B;
    localparam logic [7:0] ASC_COLON = 8'h3A;
    localparam logic [7:0] ASC_U     = 8'h75;
    localparam logic [7:0] ASC_ZERO  = 8'h30;

    // event code of a plain press
    localparam logic [1:0] EVT_PRESS = 2'd1;

    // configuration register indexes
    localparam logic [1:0] CFG_ENABLE    = 2'd0;
    localparam logic [1:0] CFG_EVENTS    = 2'd1;
    localparam logic [1:0] CFG_ALTERNATE = 2'd2;
    localparam logic [1:0] CFG_TEXT      = 2'd3;

    localparam int KEY_W    = 21;
    localparam int DIGITS   = 7;
    localparam int NUMS     = 8;
    localparam int BITS_CYC = 3;
    localparam int CONV_CYC = KEY_W / BITS_CYC;

    // number slots inside a job
    localparam logic [2:0] NUM_KEY  = 3'd0;
    localparam logic [2:0] NUM_SHK  = 3'd1;
    localparam logic [2:0] NUM_BSK  = 3'd2;
    localparam logic [2:0] NUM_MODS = 3'd3;
    localparam logic [2:0] NUM_TXT0 = 3'd4;

    typedef logic [DIGITS-1:0][3:0] t_bcd;

    typedef struct packed {
        t_bcd [NUMS-1:0] num;
        logic [1:0]      evt;
        logic            has_shk;
        logic            has_bsk;
        logic            has_evt;
        logic            has_txt;
        logic            mods_grp;
        logic [3:0]      tlen;
    } t_job;

    typedef struct packed {
        logic enable;
        logic events;
        logic alternate;
        logic text;
    } t_cfg;

    typedef enum logic [1:0] {F_IDLE, F_CONV, F_PUSH} t_fstate;

    typedef enum logic [3:0] {
        B_ESC, B_LBR, B_NUM, B_C1, B_C2, B_SEMI1, B_C3, B_EVT, B_SEMI2, B_TC, B_U
    } t_bstate;

    // one shift-add-3 step of binary to bcd conversion
    function automatic t_bcd dabble_step(input t_bcd bcd, input logic b);
        t_bcd                  t;
        logic [DIGITS*4-1:0]   v;
        t = bcd;
        for (int d = 0; d < DIGITS; d++) begin
            if (t[d] >= 4'd5) begin
                t[d] = t[d] + 4'd3;
            end
        end
        v = t;
        return t_bcd'({v[DIGITS*4-2:0], b});
    endfunction

    // position of the most significant nonzero digit, zero if none
    function automatic logic [2:0] top_digit(input t_bcd bcd);
        logic [2:0] p;
        p = 3'd0;
        for (int d = 0; d < DIGITS; d++) begin
            if (bcd[d] != 4'd0) begin
                p = 3'(d);
            end
        end
        return p;
    endfunction

endpackage

[hw/rtl/kecu_front.sv]
module kecu_front #(
    parameter int MAX_TEXT_BYTES = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [20:0]          i_key,
    input  logic [20:0]          i_shift_key,
    input  logic [20:0]          i_base,
    input  logic [7:0]           i_modifiers,
    input  logic [1:0]           i_evt,
    input  logic [2:0]           i_text_len,
    input  logic [31:0]          i_text_bytes,
    input  kecu_pkg::t_cfg       i_cfg,
    output logic                 o_push,
    output kecu_pkg::t_job       o_job,
    input  logic                 i_full
);

    kecu_pkg::t_fstate r_state, n_state;
    logic [2:0]        r_cnt;
    logic [kecu_pkg::NUMS-1:0][kecu_pkg::KEY_W-1:0] r_bin;
    kecu_pkg::t_job    r_job;
    logic              accept;
    logic [7:0]        mods;
    logic [3:0]        tlen;

    assign o_ready = (r_state == kecu_pkg::F_IDLE);
    assign accept  = i_valid && o_ready;
    assign o_push  = (r_state == kecu_pkg::F_PUSH) && !i_full;
    assign o_job   = r_job;

    assign mods = i_modifiers + 8'd1;
    assign tlen = ({1'b0, i_text_len} > 4'(MAX_TEXT_BYTES)) ? 4'(MAX_TEXT_BYTES)
                                                            : {1'b0, i_text_len};

    // control sequence
    always_comb begin
        n_state = r_state;
        case (r_state)
            kecu_pkg::F_IDLE: if (accept && i_cfg.enable) n_state = kecu_pkg::F_CONV;
            kecu_pkg::F_CONV: if (r_cnt == 3'(kecu_pkg::CONV_CYC - 1)) n_state = kecu_pkg::F_PUSH;
            kecu_pkg::F_PUSH: if (!i_full) n_state = kecu_pkg::F_IDLE;
            default:          n_state = kecu_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kecu_pkg::F_IDLE;
            r_cnt   <= 3'd0;
        end else begin
            r_state <= n_state;
            if (r_state == kecu_pkg::F_CONV) begin
                r_cnt <= r_cnt + 3'd1;
            end else begin
                r_cnt <= 3'd0;
            end
        end
    end

    // capture the event, then convert every number three bits a cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_bin[0] <= i_key;
            r_bin[1] <= i_shift_key;
            r_bin[2] <= i_base;
            r_bin[3] <= {13'd0, mods};
            for (int k = 0; k < 4; k++) begin
                r_bin[4+k] <= {13'd0, i_text_bytes[8*k +: 8]};
            end
            r_job.num      <= '0;
            r_job.evt      <= i_evt;
            r_job.has_shk  <= i_cfg.alternate && (i_shift_key != 21'd0);
            r_job.has_bsk  <= i_cfg.alternate && (i_base != 21'd0);
            r_job.has_evt  <= i_cfg.events && (i_evt != kecu_pkg::EVT_PRESS);
            r_job.has_txt  <= i_cfg.text && (tlen != 4'd0);
            r_job.mods_grp <= (mods > 8'd1)
                              || (i_cfg.events && (i_evt != kecu_pkg::EVT_PRESS))
                              || (i_cfg.text && (tlen != 4'd0));
            r_job.tlen     <= tlen;
        end else if (r_state == kecu_pkg::F_CONV) begin
            for (int k = 0; k < kecu_pkg::NUMS; k++) begin
                r_job.num[k] <= kecu_pkg::dabble_step(
                    kecu_pkg::dabble_step(
                        kecu_pkg::dabble_step(r_job.num[k], r_bin[k][20]),
                        r_bin[k][19]),
                    r_bin[k][18]);
                r_bin[k] <= {r_bin[k][17:0], 3'd0};
            end
        end
    end

endmodule

[hw/rtl/kecu_fifo.sv]
module kecu_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  kecu_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output kecu_pkg::t_job o_job
);

    kecu_pkg::t_job r_mem [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    // two entry job queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

[hw/rtl/kecu_back.sv]
module kecu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  kecu_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_tvalid,
    input  logic           i_tready,
    output logic [7:0]     o_byte,
    output logic           o_last
);

    kecu_pkg::t_bstate r_state, n_state;
    logic [2:0] r_sel, n_sel;
    logic [2:0] r_pos, n_pos;
    logic       r_zero, n_zero;
    logic [2:0] r_ti, n_ti;
    logic       r_ovalid;
    logic [7:0] r_obyte, n_byte;
    logic       r_olast, n_last;
    logic       emit;
    logic [3:0] digit;
    logic [3:0] ti_next;

    assign emit     = i_valid && (!r_ovalid || i_tready);
    assign o_tvalid = r_ovalid;
    assign o_byte   = r_obyte;
    assign o_last   = r_olast;
    assign o_pop    = emit && (r_state == kecu_pkg::B_U);
    assign digit    = r_zero ? 4'd0 : i_job.num[r_sel][r_pos];
    assign ti_next  = {1'b0, r_ti} + 4'd1;

    // byte sequencer
    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_pos   = r_pos;
        n_zero  = r_zero;
        n_ti    = r_ti;
        n_byte  = kecu_pkg::ASC_U;
        n_last  = 1'b0;
        case (r_state)
            kecu_pkg::B_ESC: begin
                n_byte  = kecu_pkg::ASC_ESC;
                n_state = kecu_pkg::B_LBR;
            end
            kecu_pkg::B_LBR: begin
                n_byte  = kecu_pkg::ASC_LBR;
                n_state = kecu_pkg::B_NUM;
                n_sel   = kecu_pkg::NUM_KEY;
                n_zero  = 1'b0;
                n_pos   = kecu_pkg::top_digit(i_job.num[kecu_pkg::NUM_KEY]);
            end
            kecu_pkg::B_NUM: begin
                n_byte = kecu_pkg::ASC_ZERO | {4'd0, digit};
                if (r_pos != 3'd0) begin
                    n_pos = r_pos - 3'd1;
                end else if (r_sel == kecu_pkg::NUM_KEY) begin
                    if (i_job.has_shk || i_job.has_bsk) n_state = kecu_pkg::B_C1;
                    else if (i_job.mods_grp)            n_state = kecu_pkg::B_SEMI1;
                    else                                n_state = kecu_pkg::B_U;
                end else if (r_sel == kecu_pkg::NUM_SHK) begin
                    if (i_job.has_bsk)       n_state = kecu_pkg::B_C2;
                    else if (i_job.mods_grp) n_state = kecu_pkg::B_SEMI1;
                    else                     n_state = kecu_pkg::B_U;
                end else if (r_sel == kecu_pkg::NUM_BSK) begin
                    if (i_job.mods_grp) n_state = kecu_pkg::B_SEMI1;
                    else                n_state = kecu_pkg::B_U;
                end else if (r_sel == kecu_pkg::NUM_MODS) begin
                    if (i_job.has_evt)      n_state = kecu_pkg::B_C3;
                    else if (i_job.has_txt) n_state = kecu_pkg::B_SEMI2;
                    else                    n_state = kecu_pkg::B_U;
                end else begin
                    if (ti_next < i_job.tlen) begin
                        n_state = kecu_pkg::B_TC;
                        n_ti    = ti_next[2:0];
                    end else begin
                        n_state = kecu_pkg::B_U;
                    end
                end
            end
            kecu_pkg::B_C1: begin
                n_byte = kecu_pkg::ASC_COLON;
                if (i_job.has_shk) begin
                    n_state = kecu_pkg::B_NUM;
                    n_sel   = kecu_pkg::NUM_SHK;
                    n_zero  = 1'b0;
                    n_pos   = kecu_pkg::top_digit(i_job.num[kecu_pkg::NUM_SHK]);
                end else begin
                    n_state = kecu_pkg::B_C2;
                end
            end
            kecu_pkg::B_C2: begin
                n_byte  = kecu_pkg::ASC_COLON;
                n_state = kecu_pkg::B_NUM;
                n_sel   = kecu_pkg::NUM_BSK;
                n_zero  = 1'b0;
                n_pos   = kecu_pkg::top_digit(i_job.num[kecu_pkg::NUM_BSK]);
            end
            kecu_pkg::B_SEMI1: begin
                n_byte  = kecu_pkg::ASC_SEMI;
                n_state = kecu_pkg::B_NUM;
                n_sel   = kecu_pkg::NUM_MODS;
                n_zero  = 1'b0;
                n_pos   = kecu_pkg::top_digit(i_job.num[kecu_pkg::NUM_MODS]);
            end
            kecu_pkg::B_C3: begin
                n_byte  = kecu_pkg::ASC_COLON;
                n_state = kecu_pkg::B_EVT;
            end
            kecu_pkg::B_EVT: begin
                n_byte = kecu_pkg::ASC_ZERO | {6'd0, i_job.evt};
                if (i_job.has_txt) n_state = kecu_pkg::B_SEMI2;
                else               n_state = kecu_pkg::B_U;
            end
            kecu_pkg::B_SEMI2: begin
                n_byte  = kecu_pkg::ASC_SEMI;
                n_state = kecu_pkg::B_NUM;
                n_ti    = 3'd0;
                n_sel   = kecu_pkg::NUM_TXT0;
                n_zero  = 1'b0;
                n_pos   = kecu_pkg::top_digit(i_job.num[kecu_pkg::NUM_TXT0]);
            end
            kecu_pkg::B_TC: begin
                // text bytes past the fourth read as zero
                n_byte  = kecu_pkg::ASC_COLON;
                n_state = kecu_pkg::B_NUM;
                n_zero  = r_ti[2];
                n_sel   = r_ti[2] ? kecu_pkg::NUM_TXT0 : {1'b1, r_ti[1:0]};
                n_pos   = r_ti[2] ? 3'd0
                                  : kecu_pkg::top_digit(i_job.num[{1'b1, r_ti[1:0]}]);
            end
            kecu_pkg::B_U: begin
                n_byte  = kecu_pkg::ASC_U;
                n_last  = 1'b1;
                n_state = kecu_pkg::B_ESC;
            end
            default: n_state = kecu_pkg::B_ESC;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kecu_pkg::B_ESC;
            r_sel    <= 3'd0;
            r_pos    <= 3'd0;
            r_zero   <= 1'b0;
            r_ti     <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (emit) begin
                r_state  <= n_state;
                r_sel    <= n_sel;
                r_pos    <= n_pos;
                r_zero   <= n_zero;
                r_ti     <= n_ti;
                r_ovalid <= 1'b1;
            end else if (i_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_obyte <= n_byte;
            r_olast <= n_last;
        end
    end

endmodule

[hw/rtl/key_event_csi_u_encoder_unit.sv]
// channel  | direction | payload
// s_axis   | in        | tdata: key, shifted key, base key, modifiers, event kind,
//          |           |        text length, text bytes
// m_axis   | out       | tdata: out_byte; tlast: last_byte
// cfg      | in        | we, addr (register index), wdata
//
// the front takes a new event only after the last one is queued: capture, the conversion
// state of the binary to bcd shifters (3 bits a cycle), then the push into the queue.
// the back sends one byte a cycle while m_axis is ready, from a two entry job queue, 4 to 48 per event.
// reset is synchronous and clears all control state and the configuration.
// m_axis stalls freeze the back only; the front keeps converting until the queue fills.
module key_event_csi_u_encoder_unit #(
    parameter int MAX_TEXT_BYTES = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // key, shifted key, base key, modifiers, event kind, text length, text bytes
    input  logic [111:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_byte
    output logic [7:0]   m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [0:0]   i_cfg_wdata
);

    kecu_pkg::t_cfg r_cfg;
    kecu_pkg::t_job push_job, head_job;
    logic           push, pop, full, head_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                kecu_pkg::CFG_ENABLE:    r_cfg.enable    <= i_cfg_wdata[0];
                kecu_pkg::CFG_EVENTS:    r_cfg.events    <= i_cfg_wdata[0];
                kecu_pkg::CFG_ALTERNATE: r_cfg.alternate <= i_cfg_wdata[0];
                kecu_pkg::CFG_TEXT:      r_cfg.text      <= i_cfg_wdata[0];
                default:                 r_cfg           <= r_cfg;
            endcase
        end
    end

    kecu_front #(.MAX_TEXT_BYTES(MAX_TEXT_BYTES)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_key        (s_axis_tdata[20:0]),
        .i_shift_key  (s_axis_tdata[41:21]),
        .i_base       (s_axis_tdata[62:42]),
        .i_modifiers  (s_axis_tdata[70:63]),
        .i_evt        (s_axis_tdata[72:71]),
        .i_text_len   (s_axis_tdata[75:73]),
        .i_text_bytes (s_axis_tdata[107:76]),
        .i_cfg        (r_cfg),
        .o_push       (push),
        .o_job        (push_job),
        .i_full       (full)
    );

    kecu_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (push_job),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(head_valid),
        .o_job  (head_job)
    );

    kecu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (head_valid),
        .i_job   (head_job),
        .o_pop   (pop),
        .o_tvalid(m_axis_tvalid),
        .i_tready(m_axis_tready),
        .o_byte  (m_axis_tdata),
        .o_last  (m_axis_tlast)
    );

endmodule

[tb/kecu_checker.sv]
`timescale 1ns / 1ps

module kecu_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [111:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [7:0]   m_axis_tdata,
    input  logic         m_axis_tlast,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_addr,
    input  logic [0:0]   i_cfg_wdata,
    output int           o_errors,
    output int           o_pending,
    output int           o_bytes,
    output int           o_events
);

    localparam int MAX_TEXT = 4;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_seq_byte;

    kecu_pkg::t_cfg cfg_q;
    t_seq_byte      seq_q[$];

    // append one expected byte
    task automatic put_byte(input logic [7:0] b, input logic l);
        t_seq_byte e;
        e.data = b;
        e.last = l;
        seq_q.insert(seq_q.size(), e);
    endtask

    // append a number in ascii decimal
    task automatic put_dec(input int unsigned v);
        logic [7:0] digs[10];
        int k;
        k = 0;
        do begin
            digs[k] = 8'(kecu_pkg::ASC_ZERO + v % 10);
            v = v / 10;
            k++;
        end while (v != 0);
        while (k > 0) begin
            k--;
            put_byte(digs[k], 1'b0);
        end
    endtask

    // expand one key event into its escape sequence
    task automatic encode_event(input logic [111:0] d);
        logic [20:0] key, shk, bsk;
        logic [7:0]  mods;
        logic [1:0]  evt;
        logic [2:0]  tlen;
        logic [31:0] text;
        int          eff_len;
        logic        has_shk, has_bsk, has_evt, has_txt;
        key  = d[20:0];
        shk  = d[41:21];
        bsk  = d[62:42];
        mods = d[70:63] + 8'd1;
        evt  = d[72:71];
        tlen = d[75:73];
        text = d[107:76];
        if (!cfg_q.enable) return;
        eff_len = (tlen > MAX_TEXT) ? MAX_TEXT : int'(tlen);
        has_shk = cfg_q.alternate && shk != 0;
        has_bsk = cfg_q.alternate && bsk != 0;
        has_evt = cfg_q.events && evt != kecu_pkg::EVT_PRESS;
        has_txt = cfg_q.text && eff_len != 0;
        put_byte(kecu_pkg::ASC_ESC, 1'b0);
        put_byte(kecu_pkg::ASC_LBR, 1'b0);
        put_dec(key);
        if (has_shk || has_bsk) begin
            put_byte(kecu_pkg::ASC_COLON, 1'b0);
            if (has_shk) put_dec(shk);
            if (has_bsk) begin
                put_byte(kecu_pkg::ASC_COLON, 1'b0);
                put_dec(bsk);
            end
        end
        if (mods > 1 || has_evt || has_txt) begin
            put_byte(kecu_pkg::ASC_SEMI, 1'b0);
            put_dec(mods);
            if (has_evt) begin
                put_byte(kecu_pkg::ASC_COLON, 1'b0);
                put_dec(evt);
            end
        end
        if (has_txt) begin
            put_byte(kecu_pkg::ASC_SEMI, 1'b0);
            for (int i = 0; i < eff_len; i++) begin
                if (i > 0) put_byte(kecu_pkg::ASC_COLON, 1'b0);
                put_dec(text[8*i +: 8]);
            end
        end
        put_byte(kecu_pkg::ASC_U, 1'b1);
    endtask

    // track configuration, predict on input transfers, compare output transfers
    always @(posedge i_clk) begin
        t_seq_byte exp_b;
        int        errs;
        errs = 0;
        if (!i_rst_n) begin
            cfg_q     <= '0;
            o_errors  <= 0;
            o_bytes   <= 0;
            o_events  <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    kecu_pkg::CFG_ENABLE:    cfg_q.enable    <= i_cfg_wdata[0];
                    kecu_pkg::CFG_EVENTS:    cfg_q.events    <= i_cfg_wdata[0];
                    kecu_pkg::CFG_ALTERNATE: cfg_q.alternate <= i_cfg_wdata[0];
                    kecu_pkg::CFG_TEXT:      cfg_q.text      <= i_cfg_wdata[0];
                    default:                 ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                encode_event(s_axis_tdata);
                o_events <= o_events + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                o_bytes <= o_bytes + 1;
                if (seq_q.size() == 0) begin
                    $error("unexpected byte transfer %h", m_axis_tdata);
                    errs++;
                end else begin
                    exp_b = seq_q.pop_front();
                    if (exp_b.data !== m_axis_tdata) begin
                        $error("out_byte expected %h actual %h", exp_b.data, m_axis_tdata);
                        errs++;
                    end
                    if (exp_b.last !== m_axis_tlast) begin
                        $error("last_byte expected %b actual %b", exp_b.last, m_axis_tlast);
                        errs++;
                    end
                end
            end
            o_errors  <= o_errors + errs;
            o_pending <= seq_q.size();
        end
    end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int LIMIT = 1000000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [111:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [7:0]   m_axis_tdata;
    logic         m_axis_tlast;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_addr;
    logic [0:0]   i_cfg_wdata;
    int           errors, pending, bytes_seen, events_seen;
    int           cycles;
    logic         stall_long;

    key_event_csi_u_encoder_unit u_dut (.*);

    kecu_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr), .i_cfg_wdata(i_cfg_wdata),
        .o_errors(errors), .o_pending(pending), .o_bytes(bytes_seen),
        .o_events(events_seen)
    );

    // clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // watchdog
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > LIMIT) begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // receiver: random gaps per byte, long hold-off on request
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        forever begin
            if (stall_long) begin
                m_axis_tready <= 1'b0;
                repeat (300) @(posedge i_clk);
                stall_long = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic cfg_write(input logic [1:0] addr, input logic val);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic set_modes(input logic en, input logic ev, input logic alt,
                             input logic txt);
        cfg_write(kecu_pkg::CFG_ENABLE, en);
        cfg_write(kecu_pkg::CFG_EVENTS, ev);
        cfg_write(kecu_pkg::CFG_ALTERNATE, alt);
        cfg_write(kecu_pkg::CFG_TEXT, txt);
        i_cfg_we <= 1'b0;
    endtask

    // one key event transfer with a given gap ahead of it
    task automatic send_event(input logic [20:0] key, input logic [20:0] shk,
                              input logic [20:0] bsk, input logic [7:0] mods,
                              input logic [1:0] evt, input logic [2:0] tlen,
                              input logic [31:0] text, input int gap);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, text, tlen, evt, mods, bsk, shk, key};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    function automatic logic [20:0] rand_key();
        case ($urandom_range(0, 4))
            0: rand_key = 21'($urandom_range(0, 9));
            1: rand_key = 21'($urandom_range(0, 999));
            2: rand_key = 21'h1FFFFF - 21'($urandom_range(0, 3));
            3: rand_key = 21'd0;
            default: rand_key = 21'($urandom);
        endcase
    endfunction

    function automatic int rand_gap();
        rand_gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
    endfunction

    // stop offering and wait until every expected byte has come
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // drain all pending bytes, then let the front settle before a config write
    task automatic wait_idle();
        drain();
        repeat (40) @(posedge i_clk);
    endtask

    task automatic random_events(input int count);
        for (int i = 0; i < count; i++) begin
            send_event(rand_key(), rand_key(), rand_key(), 8'($urandom),
                       2'($urandom), 3'($urandom), $urandom, rand_gap());
        end
    endtask

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_we      = 1'b0;
        i_cfg_addr    = kecu_pkg::CFG_ENABLE;
        i_cfg_wdata   = 1'b0;
        stall_long    = 1'b0;
        i_rst_n       = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled: events are swallowed
        send_event(21'd97, 21'd65, 21'd97, 8'd0, 2'd1, 3'd1, 32'h61, 0);
        send_event(21'h1FFFFF, 21'd0, 21'd0, 8'd255, 2'd3, 3'd4, 32'hFFFFFFFF, 2);
        wait_idle();

        // all features on: extremes and special cases
        set_modes(1'b1, 1'b1, 1'b1, 1'b1);
        send_event(21'd0, 21'd0, 21'd0, 8'd0, 2'd1, 3'd0, 32'h0, 0);
        send_event(21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 8'd254, 2'd3, 3'd4,
                   32'hFFFFFFFF, 0);
        send_event(21'd97, 21'd0, 21'd98, 8'd0, 2'd1, 3'd0, 32'h0, 0);
        send_event(21'd97, 21'd65, 21'd0, 8'd1, 2'd2, 3'd0, 32'h0, 1);
        send_event(21'd97, 21'd0, 21'd0, 8'd255, 2'd1, 3'd0, 32'h0, 0);
        send_event(21'd97, 21'd0, 21'd0, 8'd255, 2'd0, 3'd0, 32'h0, 0);
        send_event(21'd97, 21'd0, 21'd0, 8'd255, 2'd1, 3'd2, 32'h00FF0A61, 3);
        send_event(21'd13, 21'd0, 21'd0, 8'd0, 2'd3, 3'd7, 32'h80402010, 0);
        send_event(21'd13, 21'd0, 21'd0, 8'd8, 2'd2, 3'd5, 32'h01020304, 0);
        send_event(21'd57344, 21'd1, 21'd9, 8'd9, 2'd3, 3'd1, 32'h00000000, 5);
        wait_idle();

        // only the base state: modifier group alone
        set_modes(1'b1, 1'b0, 1'b0, 1'b0);
        send_event(21'd97, 21'd65, 21'd98, 8'd255, 2'd3, 3'd4, 32'h41424344, 0);
        send_event(21'd97, 21'd65, 21'd98, 8'd5, 2'd2, 3'd4, 32'h41424344, 0);
        send_event(21'd9, 21'd0, 21'd0, 8'd0, 2'd0, 3'd0, 32'h0, 0);
        random_events(40);
        wait_idle();

        // back pressure: receiver holds off while the sender keeps offering
        set_modes(1'b1, 1'b1, 1'b1, 1'b1);
        stall_long = 1'b1;
        for (int i = 0; i < 8; i++) begin
            send_event(21'h1FFFFF, 21'h1FFFFF, 21'h1FFFFF, 8'd200, 2'd3, 3'd4,
                       $urandom, 0);
        end
        // sender pause until the block drains
        drain();
        random_events(60);
        wait_idle();

        // mixed settings
        set_modes(1'b1, 1'b1, 1'b0, 1'b0);
        random_events(35);
        wait_idle();
        set_modes(1'b1, 1'b0, 1'b1, 1'b1);
        random_events(35);
        wait_idle();
        set_modes(1'b1, 1'b1, 1'b1, 1'b1);
        random_events(50);
        wait_idle();
        set_modes(1'b0, 1'b1, 1'b1, 1'b1);
        random_events(5);
        wait_idle();

        $display("covered %0d key events and %0d output bytes across six mode settings",
                 events_seen, bytes_seen);
        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/kecu_pkg.sv
hw/rtl/kecu_front.sv
hw/rtl/kecu_fifo.sv
hw/rtl/kecu_back.sv
hw/rtl/key_event_csi_u_encoder_unit.sv
tb/kecu_checker.sv
tb/tb_top.sv
